@@ rtl/nsp_pkg.sv @@
// Shared types, constants and helpers of the nested section profiler.
package nsp_pkg;

  localparam int SLOTS          = 32;
  localparam int HISTORY_FRAMES = 20;

  localparam int SLOT_W  = 5;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int HIST_W  = 5;
  localparam int TS_W    = 63;
  localparam int ACC_W   = 64;
  localparam int TPS_W   = 41;
  localparam int DS_W    = 32;
  localparam int DEN_W   = TPS_W + DS_W;
  localparam int QUO_W   = 34;
  localparam int STEP_W  = 6;
  localparam int CFG_W   = 41;
  localparam int IDX_W   = 3;

  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_END   = 2'd1;
  localparam logic [1:0] CMD_FRAME = 2'd2;

  localparam logic [IDX_W-1:0] REG_ACTIVE = 3'd0;
  localparam logic [IDX_W-1:0] REG_REPORT = 3'd1;
  localparam logic [IDX_W-1:0] REG_REF    = 3'd2;
  localparam logic [IDX_W-1:0] REG_TPS    = 3'd3;
  localparam logic [IDX_W-1:0] REG_SCALE  = 3'd4;
  localparam logic [IDX_W-1:0] REG_BIAS   = 3'd5;

  typedef enum logic [1:0] {OP_BEGIN, OP_END, OP_FRAME} op_t;

  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] slot;
    logic [TS_W-1:0]   timestamp;
  } item_t;

  typedef struct packed {
    logic [5:0]       active_slots;
    logic [5:0]       report_slots;
    logic [4:0]       reference_slot;
    logic [TPS_W-1:0] ticks_per_second;
    logic [DS_W-1:0]  disp_div;
    logic [31:0]      offset_bias;
  } cfg_t;

  function automatic logic [CNT_W-1:0] slot_limit(input logic [5:0] active);
    logic [CNT_W-1:0] a;
    a = CNT_W'(active);
    return (a < CNT_W'(SLOTS)) ? a : CNT_W'(SLOTS);
  endfunction

  function automatic logic slot_ok(input logic [SLOT_W-1:0] s, input logic [5:0] active);
    return (s != '0) && (CNT_W'(s) < slot_limit(active));
  endfunction

endpackage

@@ rtl/nsp_event_if.sv @@
// Event channel: begin, end and frame-end requests.
interface nsp_event_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [4:0]  slot;
  logic [62:0] timestamp;
  modport source(output valid, cmd, slot, timestamp, input ready);
  modport sink(input valid, cmd, slot, timestamp, output ready);
endinterface

@@ rtl/nsp_report_if.sv @@
// Report channel: one request per reported slot at frame end, or one empty report.
interface nsp_report_if;
  logic        valid;
  logic        ready;
  logic [4:0]  report_slot;
  logic        has_slot;
  logic [31:0] hits;
  logic [31:0] busy_seconds;
  logic [31:0] start_offset;
  logic [31:0] exit_offset;
  logic [4:0]  ring_position;
  logic        wrapped;
  logic        last;
  modport source(output valid, report_slot, has_slot, hits, busy_seconds, start_offset,
                 exit_offset, ring_position, wrapped, last, input ready);
  modport sink(input valid, report_slot, has_slot, hits, busy_seconds, start_offset,
               exit_offset, ring_position, wrapped, last, output ready);
endinterface

@@ rtl/nsp_front.sv @@
// Front end: accept events, drop ignored ones, queue the rest.
module nsp_front (
  input  logic          clk,
  input  logic          rst,
  input  nsp_pkg::cfg_t cfg,
  nsp_event_if.sink     events,
  output nsp_pkg::item_t head,
  output logic          head_valid,
  input  logic          head_pop
);
  import nsp_pkg::*;

  item_t      q [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  item_t      in_item;
  logic       keep;
  logic       push;

  assign events.ready = (count != 2'd2);
  assign head         = q[rp];
  assign head_valid   = (count != 2'd0);

  always_comb begin
    in_item.op        = OP_FRAME;
    in_item.slot      = events.slot;
    in_item.timestamp = events.timestamp;
    keep              = 1'b0;
    unique case (events.cmd)
      CMD_BEGIN: begin
        in_item.op = OP_BEGIN;
        keep       = slot_ok(events.slot, cfg.active_slots);
      end
      CMD_END: begin
        in_item.op = OP_END;
        keep       = slot_ok(events.slot, cfg.active_slots);
      end
      CMD_FRAME: begin
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign push = events.valid && events.ready && keep;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (head_pop) begin
        rp <= ~rp;
      end
      count <= count + {1'b0, push} - {1'b0, head_pop};
    end
  end

endmodule

@@ rtl/nsp_div.sv @@
// Restoring divider, one quotient bit per cycle, with overflow detect.
module nsp_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [63:0]                 hi,
  input  logic [nsp_pkg::QUO_W-1:0]   lo,
  input  logic [nsp_pkg::STEP_W-1:0]  steps,
  input  logic [nsp_pkg::DEN_W-1:0]   den,
  output logic                        done,
  output logic [nsp_pkg::QUO_W-1:0]   quo,
  output logic                        ovf
);
  import nsp_pkg::*;

  logic              run;
  logic [STEP_W-1:0] cnt;
  logic [DEN_W-1:0]  rem;
  logic [QUO_W-1:0]  sr;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              fits;

  assign trial = {rem, sr[QUO_W-1]};
  assign diff  = trial - {1'b0, den};
  assign fits  = trial >= {1'b0, den};
  assign quo   = sr;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      ovf  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (DEN_W'(hi) >= den) begin
          ovf  <= 1'b1;
          done <= 1'b1;
          run  <= 1'b0;
        end else begin
          rem <= DEN_W'(hi);
          sr  <= lo;
          cnt <= steps;
          ovf <= 1'b0;
          run <= 1'b1;
        end
      end else if (run) begin
        rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        sr  <= {sr[QUO_W-2:0], fits};
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/nsp_back.sv @@
// Back end: slot counters, frame-end sequencer and report register.
module nsp_back (
  input  logic           clk,
  input  logic           rst,
  input  nsp_pkg::cfg_t  cfg,
  input  nsp_pkg::item_t head,
  input  logic           head_valid,
  output logic           head_pop,
  nsp_report_if.source   reports
);
  import nsp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_SUM, ST_LOAD, ST_ISSUE, ST_WAIT, ST_EMIT
  } state_t;

  logic [31:0]      hit_counts   [SLOTS];
  logic [15:0]      nest_depths  [SLOTS];
  logic [ACC_W-1:0] accumulated  [SLOTS];
  logic [TS_W-1:0]  section_start[SLOTS];
  logic [TS_W-1:0]  entry_stamp  [SLOTS];
  logic [TS_W-1:0]  exit_stamp   [SLOTS];
  logic [SLOTS-1:0] entry_valid;

  state_t            state;
  logic [SLOT_W-1:0] idx;
  logic [CNT_W-1:0]  bound;
  logic [1:0]        phase;
  logic              empty;
  logic [TS_W-1:0]   origin;
  logic [63:0]       prod_lo;
  logic [DEN_W-33:0] prod_hi;
  logic [DEN_W-1:0]  den;
  logic [HIST_W-1:0] hist;
  logic [HIST_W-1:0] pos;
  logic              wrap;
  logic [31:0]       wk_hits;
  logic [ACC_W-1:0]  wk_acc;
  logic [TS_W-1:0]   wk_first;
  logic [TS_W-1:0]   wk_last;
  logic [31:0]       busy_q;
  logic [31:0]       start_q;
  logic [31:0]       end_q;

  logic              out_valid;
  logic [4:0]        report_slot;
  logic              has_slot;
  logic [31:0]       hits;
  logic [31:0]       busy_seconds;
  logic [31:0]       start_offset;
  logic [31:0]       exit_offset;
  logic [4:0]        ring_position;
  logic              wrapped;
  logic              last;

  logic [SLOT_W-1:0] rd_idx;
  logic [31:0]       rd_hits;
  logic [15:0]       rd_depth;
  logic [ACC_W-1:0]  rd_acc;
  logic [TS_W-1:0]   rd_start;
  logic [TS_W-1:0]   rd_first;
  logic [TS_W-1:0]   rd_last;

  logic              wr_en;
  logic [31:0]       wr_hits;
  logic [15:0]       wr_depth;
  logic [ACC_W-1:0]  wr_acc;
  logic [TS_W-1:0]   wr_start;
  logic [TS_W-1:0]   wr_first;
  logic [TS_W-1:0]   wr_last;
  logic [15:0]       dec_depth;

  logic [TPS_W-1:0]  tps_eff;
  logic [DS_W-1:0]   ds_eff;
  logic [CNT_W-1:0]  lim;
  logic [CNT_W-1:0]  rep_lim;
  logic [HIST_W:0]   adv;

  logic              div_start;
  logic [63:0]       div_hi;
  logic [QUO_W-1:0]  div_lo;
  logic [STEP_W-1:0] div_steps;
  logic [DEN_W-1:0]  div_den;
  logic              div_done;
  logic [QUO_W-1:0]  div_quo;
  logic              div_ovf;

  logic [TS_W-1:0]   off_time;
  logic [63:0]       delta;
  logic              neg;
  logic [63:0]       mag;
  logic [QUO_W-1:0]  mag_q;
  logic signed [35:0] off_sum;
  logic [31:0]       off_sat;
  logic [31:0]       busy_val;
  logic              emit_ok;

  assign tps_eff = (cfg.ticks_per_second == '0) ? TPS_W'(1) : cfg.ticks_per_second;
  assign ds_eff  = (cfg.disp_div == '0) ? DS_W'(1) : cfg.disp_div;
  assign lim     = slot_limit(cfg.active_slots);
  assign rep_lim = (CNT_W'(cfg.report_slots) < lim) ? CNT_W'(cfg.report_slots) : lim;
  assign adv     = {1'b0, hist} + (HIST_W+1)'(1);
  assign emit_ok = !out_valid || reports.ready;

  assign rd_idx   = (state != ST_IDLE) ? idx :
                    (head.op == OP_FRAME) ? cfg.reference_slot : head.slot;
  assign rd_hits  = entry_valid[rd_idx] ? hit_counts[rd_idx]    : '0;
  assign rd_depth = entry_valid[rd_idx] ? nest_depths[rd_idx]   : '0;
  assign rd_acc   = entry_valid[rd_idx] ? accumulated[rd_idx]   : '0;
  assign rd_start = entry_valid[rd_idx] ? section_start[rd_idx] : '0;
  assign rd_first = entry_valid[rd_idx] ? entry_stamp[rd_idx]   : '0;
  assign rd_last  = entry_valid[rd_idx] ? exit_stamp[rd_idx]    : '0;
  assign dec_depth = rd_depth - 16'd1;

  always_comb begin
    head_pop = (state == ST_IDLE) && head_valid;
    wr_en    = 1'b0;
    wr_hits  = rd_hits;
    wr_depth = rd_depth;
    wr_acc   = rd_acc;
    wr_start = rd_start;
    wr_first = rd_first;
    wr_last  = rd_last;
    if (state == ST_IDLE && head_valid) begin
      unique case (head.op)
        OP_BEGIN: begin
          wr_en    = 1'b1;
          wr_hits  = rd_hits + 32'd1;
          wr_depth = rd_depth + 16'd1;
          if (rd_depth == 16'd0) begin
            wr_start = head.timestamp;
            if (rd_acc == '0) begin
              wr_first = head.timestamp;
            end
          end
        end
        OP_END: begin
          wr_en    = 1'b1;
          wr_depth = dec_depth;
          if (dec_depth == 16'd0) begin
            wr_acc  = rd_acc + ({1'b0, head.timestamp} - {1'b0, rd_start});
            wr_last = head.timestamp;
          end
        end
        default: wr_en = 1'b0;
      endcase
    end else if (state == ST_LOAD) begin
      wr_en    = 1'b1;
      wr_hits  = '0;
      wr_depth = '0;
      wr_acc   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hit_counts[rd_idx]    <= wr_hits;
      nest_depths[rd_idx]   <= wr_depth;
      accumulated[rd_idx]   <= wr_acc;
      section_start[rd_idx] <= wr_start;
      entry_stamp[rd_idx]   <= wr_first;
      exit_stamp[rd_idx]    <= wr_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (wr_en) begin
      entry_valid[rd_idx] <= 1'b1;
    end
  end

  // divider operands for busy time, start offset and end offset
  assign off_time = (phase == 2'd1) ? wk_first : wk_last;
  assign delta    = {1'b0, off_time} - {1'b0, origin};
  assign neg      = delta[63];
  assign mag      = neg ? (64'd0 - delta) : delta;

  always_comb begin
    div_start = (state == ST_ISSUE);
    if (phase == 2'd0) begin
      div_hi    = {16'd0, wk_acc[63:16]};
      div_lo    = {wk_acc[15:0], 18'd0};
      div_steps = STEP_W'(32);
      div_den   = DEN_W'(tps_eff);
    end else begin
      div_hi    = {2'd0, mag[63:2]};
      div_lo    = {mag[1:0], 32'd0};
      div_steps = STEP_W'(QUO_W);
      div_den   = den;
    end
  end

  nsp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .hi    (div_hi),
    .lo    (div_lo),
    .steps (div_steps),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .ovf   (div_ovf)
  );

  always_comb begin
    busy_val = wk_acc[63] ? 32'd0 : (div_ovf ? 32'hFFFF_FFFF : div_quo[31:0]);
    mag_q    = (div_ovf || div_quo > QUO_W'(34'h2_0000_0000)) ?
               QUO_W'(34'h2_0000_0000) : div_quo;
    off_sum  = (neg ? -$signed({2'b00, mag_q}) : $signed({2'b00, mag_q}))
               + $signed({{4{cfg.offset_bias[31]}}, cfg.offset_bias});
    if (off_sum > 36'sd2147483647) begin
      off_sat = 32'h7FFF_FFFF;
    end else if (off_sum < -36'sd2147483648) begin
      off_sat = 32'h8000_0000;
    end else begin
      off_sat = off_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      hist      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_EMIT && emit_ok) begin
        out_valid <= 1'b1;
      end else if (reports.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (head_valid && head.op == OP_FRAME) begin
            origin <= slot_ok(cfg.reference_slot, cfg.active_slots) ? rd_first : '0;
            pos    <= hist;
            wrap   <= (adv >= (HIST_W+1)'(HISTORY_FRAMES));
            hist   <= (adv >= (HIST_W+1)'(HISTORY_FRAMES)) ? '0 : adv[HIST_W-1:0];
            bound  <= rep_lim;
            idx    <= SLOT_W'(1);
            state  <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_lo <= 64'(tps_eff[31:0]) * 64'(ds_eff);
          prod_hi <= (DEN_W-32)'(tps_eff[TPS_W-1:32]) * (DEN_W-32)'(ds_eff);
          state   <= ST_SUM;
        end
        ST_SUM: begin
          den   <= {prod_hi, 32'd0} + DEN_W'(prod_lo);
          empty <= (bound <= CNT_W'(1));
          state <= (bound <= CNT_W'(1)) ? ST_EMIT : ST_LOAD;
        end
        ST_LOAD: begin
          wk_hits  <= rd_hits;
          wk_acc   <= rd_acc;
          wk_first <= rd_first;
          wk_last  <= rd_last;
          phase    <= 2'd0;
          state    <= ST_ISSUE;
        end
        ST_ISSUE: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (div_done) begin
            if (phase == 2'd0) begin
              busy_q <= busy_val;
            end else if (phase == 2'd1) begin
              start_q <= off_sat;
            end else begin
              end_q <= off_sat;
            end
            if (phase == 2'd2) begin
              state <= ST_EMIT;
            end else begin
              phase <= phase + 2'd1;
              state <= ST_ISSUE;
            end
          end
        end
        ST_EMIT: begin
          if (emit_ok) begin
            report_slot   <= empty ? 5'd0 : idx;
            has_slot      <= !empty;
            hits          <= empty ? 32'd0 : wk_hits;
            busy_seconds  <= empty ? 32'd0 : busy_q;
            start_offset  <= empty ? 32'd0 : start_q;
            exit_offset   <= empty ? 32'd0 : end_q;
            ring_position <= pos;
            wrapped       <= wrap;
            if (empty || CNT_W'(idx) == bound - CNT_W'(1)) begin
              last  <= 1'b1;
              state <= ST_IDLE;
            end else begin
              last  <= 1'b0;
              idx   <= idx + SLOT_W'(1);
              state <= ST_LOAD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign reports.valid         = out_valid;
  assign reports.report_slot   = report_slot;
  assign reports.has_slot      = has_slot;
  assign reports.hits          = hits;
  assign reports.busy_seconds  = busy_seconds;
  assign reports.start_offset  = start_offset;
  assign reports.exit_offset   = exit_offset;
  assign reports.ring_position = ring_position;
  assign reports.wrapped       = wrapped;
  assign reports.last          = last;

endmodule

@@ rtl/nested_section_profiler_core.sv @@
// Top level of the nested section profiler: config registers, front and back ends.
//
// Requests arrive on the events channel (valid/ready): begin, end or frame end
// with a slot and a 63-bit timestamp. Begin and end requests for slot 0 or an
// inactive slot, and unknown commands, are accepted and dropped.
// A two-entry queue parts the front from the back end. A begin or end request
// updates its slot when the back end pops it from the queue, so a stream of them
// runs at one per cycle while the back end is idle.
// A frame end emits one report request per reported slot (or one empty report)
// on the reports channel, the final one marked with last. Each slot passes
// through one load, three divisions on one shared bit-serial divider and one
// emit; the frame start first passes through a multiply and a sum state.
// Meanwhile the queue fills and then holds events.ready low.
// A stalled receiver holds the report register; the sequencer waits for it.
// The user writes configuration through wr_en/wr_index/wr_data while idle; not enforced.
// Reset (rst, synchronous) clears all counters, loads the register defaults
// and resets the ring index; it needs no clearing pass.
module nested_section_profiler_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [nsp_pkg::IDX_W-1:0]   wr_index,
  input  logic [nsp_pkg::CFG_W-1:0]   wr_data,
  nsp_event_if.sink                   events,
  nsp_report_if.source                reports
);
  import nsp_pkg::*;

  cfg_t  cfg;
  item_t head;
  logic  head_valid;
  logic  head_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_slots     <= 6'd32;
      cfg.report_slots     <= 6'd0;
      cfg.reference_slot   <= 5'd1;
      cfg.ticks_per_second <= TPS_W'(1000000);
      cfg.disp_div         <= DS_W'(65536);
      cfg.offset_bias      <= 32'd0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ACTIVE: cfg.active_slots     <= wr_data[5:0];
        REG_REPORT: cfg.report_slots     <= wr_data[5:0];
        REG_REF:    cfg.reference_slot   <= wr_data[4:0];
        REG_TPS:    cfg.ticks_per_second <= wr_data[TPS_W-1:0];
        REG_SCALE:  cfg.disp_div         <= wr_data[DS_W-1:0];
        REG_BIAS:   cfg.offset_bias      <= wr_data[31:0];
        default: ;
      endcase
    end
  end

  nsp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .events     (events),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop)
  );

  nsp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .reports    (reports)
  );

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    reports.valid && !reports.has_slot |-> reports.last)
    else $error("empty frame report not marked last");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    reports.valid && !reports.has_slot |->
      reports.hits == 32'd0 && reports.busy_seconds == 32'd0 &&
      reports.report_slot == 5'd0)
    else $error("empty frame report carries data");

  a_ring_range: assert property (@(posedge clk) disable iff (rst)
    reports.valid |-> reports.ring_position < HIST_W'(HISTORY_FRAMES))
    else $error("ring position out of range");

  a_pop_needs_head: assert property (@(posedge clk) disable iff (rst)
    head_pop |-> head_valid)
    else $error("queue popped while empty");

endmodule

@@ sim/nsp_report_checker.sv @@
// Report checker: predicts the profiler's frame reports and compares them.
module nsp_report_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [nsp_pkg::IDX_W-1:0] wr_index,
  input  logic [nsp_pkg::CFG_W-1:0] wr_data,
  nsp_event_if                      ev,
  nsp_report_if                     rp,
  output int                        errors,
  output int                        pending
);
  import nsp_pkg::*;

  typedef struct {
    logic [4:0]  report_slot;
    logic        has_slot;
    logic [31:0] hits;
    logic [31:0] busy_seconds;
    logic [31:0] start_offset;
    logic [31:0] exit_offset;
    logic [4:0]  ring_position;
    logic        wrapped;
    logic        last;
  } frame_report_t;

  frame_report_t report_q[$];

  logic [5:0]  act_slots, rep_slots;
  logic [4:0]  ref_slot;
  logic [40:0] tps;
  logic [31:0] scale;
  logic [31:0] bias;

  logic [31:0] hit_cnt[SLOTS];
  logic [15:0] depth[SLOTS];
  logic [63:0] busy_acc[SLOTS];
  logic [63:0] sect_start[SLOTS];
  logic [63:0] first_in[SLOTS];
  logic [63:0] last_out[SLOTS];
  logic [4:0]  ring_idx;

  function automatic bit slot_live(logic [5:0] s);
    logic [5:0] lim;
    lim = (act_slots < SLOTS) ? act_slots : 6'(SLOTS);
    return s != 0 && s < lim;
  endfunction

  function automatic logic [31:0] busy_q16(logic [63:0] acc);
    logic [127:0] q;
    if (acc[63]) return 32'd0;
    q = {48'd0, acc, 16'd0} / 128'((tps == 0) ? 41'd1 : tps);
    return (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  function automatic logic [31:0] offset_q16(logic [63:0] t, logic [63:0] origin);
    logic [63:0] d, mag, v;
    logic [127:0] num, den, q;
    logic signed [65:0] s, b;
    d = t - origin;
    mag = d[63] ? -d : d;
    num = {32'd0, mag, 32'd0};
    den = 128'((tps == 0) ? 41'd1 : tps) * 128'((scale == 0) ? 32'd1 : scale);
    q = num / den;
    v = (q > 128'h2_0000_0000) ? 64'h2_0000_0000 : q[63:0];
    s = d[63] ? -$signed({2'b00, v}) : $signed({2'b00, v});
    b = $signed(bias);
    s = s + b;
    if (s > 66'sd2147483647) s = 66'sd2147483647;
    if (s < -66'sd2147483648) s = -66'sd2147483648;
    return s[31:0];
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h, expected %h", field, got, want);
    errors++;
  endtask

  task automatic apply_event(logic [1:0] cmd, logic [4:0] s, logic [62:0] ts);
    logic [63:0] origin;
    logic [4:0] pos;
    logic wrap;
    int k;
    frame_report_t r;
    if (cmd == CMD_BEGIN) begin
      if (!slot_live(6'(s))) return;
      hit_cnt[s] = hit_cnt[s] + 32'd1;
      depth[s] = depth[s] + 16'd1;
      if (depth[s] != 16'd1) return;
      if (busy_acc[s] == 0) first_in[s] = 64'(ts);
      sect_start[s] = 64'(ts);
    end else if (cmd == CMD_END) begin
      if (!slot_live(6'(s))) return;
      depth[s] = depth[s] - 16'd1;
      if (depth[s] != 16'd0) return;
      busy_acc[s] = busy_acc[s] + (64'(ts) - sect_start[s]);
      last_out[s] = 64'(ts);
    end else if (cmd == CMD_FRAME) begin
      origin = slot_live(6'(ref_slot)) ? first_in[ref_slot] : 64'd0;
      pos = ring_idx;
      wrap = (ring_idx + 1 >= HISTORY_FRAMES);
      ring_idx = wrap ? 5'd0 : ring_idx + 5'd1;
      k = 0;
      for (int i = 1; i < rep_slots && i < SLOTS; i++) begin
        if (!slot_live(6'(i))) continue;
        r.report_slot = 5'(i);
        r.has_slot = 1'b1;
        r.hits = hit_cnt[i];
        r.busy_seconds = busy_q16(busy_acc[i]);
        hit_cnt[i] = '0;
        depth[i] = '0;
        busy_acc[i] = '0;
        r.start_offset = offset_q16(first_in[i], origin);
        r.exit_offset = offset_q16(last_out[i], origin);
        r.ring_position = pos;
        r.wrapped = wrap;
        r.last = 1'b0;
        report_q.push_back(r);
        k++;
      end
      if (k == 0) begin
        r = '{5'd0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, pos, wrap, 1'b0};
        report_q.push_back(r);
      end
      report_q[$].last = 1'b1;
    end
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    frame_report_t e;
    if (rst) begin
      act_slots = 6'd32; rep_slots = 6'd0; ref_slot = 5'd1;
      tps = 41'd1000000; scale = 32'd65536; bias = 32'd0;
      for (int i = 0; i < SLOTS; i++) begin
        hit_cnt[i] = '0; depth[i] = '0; busy_acc[i] = '0;
        sect_start[i] = '0; first_in[i] = '0; last_out[i] = '0;
      end
      ring_idx = '0;
      report_q.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_ACTIVE: act_slots = wr_data[5:0];
          REG_REPORT: rep_slots = wr_data[5:0];
          REG_REF:    ref_slot = wr_data[4:0];
          REG_TPS:    tps = wr_data[40:0];
          REG_SCALE:  scale = wr_data[31:0];
          REG_BIAS:   bias = wr_data[31:0];
          default: ;
        endcase
      end
      if (ev.valid && ev.ready) apply_event(ev.cmd, ev.slot, ev.timestamp);
      if (rp.valid && rp.ready) begin
        if (report_q.size() == 0) begin
          report_mismatch("unexpected report_slot", 32'(rp.report_slot), 32'd0);
        end else begin
          e = report_q.pop_front();
          if (rp.report_slot !== e.report_slot)
            report_mismatch("report_slot", 32'(rp.report_slot), 32'(e.report_slot));
          if (rp.has_slot !== e.has_slot)
            report_mismatch("has_slot", 32'(rp.has_slot), 32'(e.has_slot));
          if (rp.hits !== e.hits) report_mismatch("hits", rp.hits, e.hits);
          if (rp.busy_seconds !== e.busy_seconds)
            report_mismatch("busy_seconds", rp.busy_seconds, e.busy_seconds);
          if (rp.start_offset !== e.start_offset)
            report_mismatch("start_offset", rp.start_offset, e.start_offset);
          if (rp.exit_offset !== e.exit_offset)
            report_mismatch("exit_offset", rp.exit_offset, e.exit_offset);
          if (rp.ring_position !== e.ring_position)
            report_mismatch("ring_position", 32'(rp.ring_position), 32'(e.ring_position));
          if (rp.wrapped !== e.wrapped)
            report_mismatch("wrapped", 32'(rp.wrapped), 32'(e.wrapped));
          if (rp.last !== e.last) report_mismatch("last", 32'(rp.last), 32'(e.last));
        end
      end
    end
    pending = report_q.size();
  end

endmodule

@@ sim/tb_nested_section_profiler_core.sv @@
// Testbench top of the nested section profiler: stimulus, idling and verdict.
module tb_nested_section_profiler_core;
  import nsp_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;

  logic clk;
  logic rst;
  logic wr_en;
  logic [IDX_W-1:0] wr_index;
  logic [CFG_W-1:0] wr_data;
  int errors, pending, cycles;
  int idle_pct, stall_pct;
  int tb_depth[SLOTS];
  logic [62:0] now_ts;
  logic [5:0] cur_active;

  nsp_event_if ev();
  nsp_report_if rp();

  nested_section_profiler_core dut (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .events(ev), .reports(rp)
  );

  nsp_report_checker u_checker (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .ev(ev), .rp(rp), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) rp.ready <= rst ? 1'b0 : ($urandom_range(99) >= stall_pct);

  task automatic send(logic [1:0] cmd, logic [4:0] s, logic [62:0] ts);
    while ($urandom_range(99) < idle_pct) begin
      ev.valid <= 1'b0;
      @(posedge clk);
    end
    ev.valid <= 1'b1;
    ev.cmd <= cmd;
    ev.slot <= s;
    ev.timestamp <= ts;
    @(posedge clk);
    while (!ev.ready) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
  endtask

  task automatic drain();
    ev.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic setup(logic [5:0] act, logic [5:0] rep, logic [4:0] rs,
                       logic [40:0] tps, logic [31:0] sc, logic [31:0] b);
    drain();
    write_reg(REG_ACTIVE, CFG_W'(act));
    write_reg(REG_REPORT, CFG_W'(rep));
    write_reg(REG_REF, CFG_W'(rs));
    write_reg(REG_TPS, CFG_W'(tps));
    write_reg(REG_SCALE, CFG_W'(sc));
    write_reg(REG_BIAS, CFG_W'(b));
    wr_en <= 1'b0;
    cur_active = act;
    foreach (tb_depth[i]) tb_depth[i] = 0;
  endtask

  task automatic random_events(int n);
    int lim, s, r;
    for (int k = 0; k < n; k++) begin
      lim = (cur_active < SLOTS) ? cur_active : SLOTS;
      r = $urandom_range(99);
      now_ts = now_ts + 63'($urandom_range(5000));
      if (r < 8) begin
        send(CMD_FRAME, 5'($urandom), now_ts);
        foreach (tb_depth[i]) tb_depth[i] = 0;
      end else if (r < 16 || lim < 2) begin
        send(2'($urandom), 5'($urandom), 63'({$urandom, $urandom} >> 1));
      end else begin
        s = $urandom_range(lim - 1, 1);
        if (tb_depth[s] > 0 && ($urandom_range(1) == 1 || tb_depth[s] > 3)) begin
          send(CMD_END, 5'(s), now_ts);
          tb_depth[s]--;
        end else begin
          send(CMD_BEGIN, 5'(s), now_ts);
          tb_depth[s]++;
        end
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    wr_en <= 1'b0;
    wr_index <= '0;
    wr_data <= '0;
    ev.valid <= 1'b0;
    ev.cmd <= CMD_BEGIN;
    ev.slot <= '0;
    ev.timestamp <= '0;
    cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    now_ts = 63'd1000;
    cur_active = 6'd32;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(CMD_FRAME, 5'd0, 63'd0);
    setup(6'd32, 6'd32, 5'd1, 41'd1000, 32'd65536, 32'd0);
    send(CMD_BEGIN, 5'd1, 63'd100);
    send(CMD_BEGIN, 5'd1, 63'd200);
    send(CMD_END, 5'd1, 63'd300);
    send(CMD_END, 5'd1, 63'd5000);
    send(CMD_BEGIN, 5'd0, 63'd10);
    send(CMD_BEGIN, 5'd31, 63'd50);
    send(CMD_END, 5'd31, {63{1'b1}});
    send(CMD_END, 5'd2, 63'd7);
    send(2'd3, 5'd5, 63'd9);
    send(CMD_BEGIN, 5'd3, {63{1'b1}});
    send(CMD_END, 5'd3, 63'd0);
    send(CMD_FRAME, 5'd31, 63'd0);
    send(CMD_BEGIN, 5'd4, 63'd0);
    send(CMD_END, 5'd4, 63'h7FFF_FFFF_FFFF);
    send(CMD_FRAME, 5'd0, 63'd0);
    setup(6'd63, 6'd5, 5'd0, 41'd0, 32'd0, 32'h7FFF_FFFF);
    send(CMD_BEGIN, 5'd2, 63'd1);
    send(CMD_END, 5'd2, 63'd900000);
    send(CMD_FRAME, 5'd0, 63'd0);

    stall_pct = 0; idle_pct = 0;
    setup(6'd32, 6'd6, 5'd1, 41'd1000, 32'd1, 32'd0);
    random_events(90);
    drain();
    random_events(10);

    idle_pct = 56; stall_pct = 0;
    setup(6'd63, 6'd32, 5'd31, 41'd0, 32'd0, 32'h7FFF_FFFF);
    random_events(90);

    idle_pct = 0; stall_pct = 56;
    setup(6'd9, 6'd12, 5'd0, 41'h100_0000_0000, 32'hFFFF_FFFF, 32'h8000_0000);
    random_events(90);

    idle_pct = 26; stall_pct = 26;
    setup(6'd20, 6'd4, 5'd5, 41'($urandom_range(100000, 1)), $urandom, $urandom);
    random_events(90);

    setup(6'd0, 6'd3, 5'd1, 41'd1000000, 32'd65536, 32'd0);
    random_events(15);

    ev.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
